### src/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Shared widths, register indexes, constant tables and types for the odometry
// core, its CORDIC unit and its shared multiplier.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int ANGLE_W    = 32;
  localparam int POS_W      = 32;
  localparam int RAD_W      = 16;
  localparam int INVSEP_W   = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;
  localparam int IN_W       = 2 * ANGLE_W;
  localparam int OUT_W      = 3 * POS_W;

  localparam int DELTA_W = ANGLE_W + 1;
  localparam int SUM_W   = DELTA_W + 1;
  localparam int DIST_W  = 34;
  localparam int TRIG_W  = 34;
  localparam int DX_W    = 36;
  localparam int T_W     = 51;
  localparam int W_W     = 59;
  localparam int OPA_W   = W_W;
  localparam int OPB_W   = TRIG_W;
  localparam int AMAG_W  = 58;
  localparam int BMAG_W  = 32;
  localparam int PP_W    = 64;
  localparam int ACC_W   = AMAG_W + BMAG_W;
  localparam int PROD_W  = ACC_W + 1;

  localparam int DIST_SHIFT  = 17;
  localparam int TRIG_SHIFT  = 30;
  localparam int OMEGA_SHIFT = 16;
  localparam int TURN_SHIFT  = 32;

  localparam int ATAN_N     = 32;
  localparam int ATAN_IDX_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SEP      = 8'd1;

  localparam logic [RAD_W-1:0]    RADIUS_RESET = 16'd8474;
  localparam logic [INVSEP_W-1:0] INVSEP_RESET = 24'd68478;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN  = 34'sd652032875;
  localparam logic [ANGLE_W-1:0]       TURN_PER_RAD = 32'd683565276;
  localparam logic [ANGLE_W-1:0]       QUARTER_TURN = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0]       HALF_TURN    = 32'h8000_0000;

  localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORDIC,
    S_DIST,
    S_DX,
    S_DY,
    S_TURN,
    S_OMEGA,
    S_DELTA,
    S_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI,
    MUL_SUM,
    MUL_SIGN
  } mul_state_t;

  typedef enum logic [1:0] {
    COR_IDLE,
    COR_RUN,
    COR_FIN
  } cordic_state_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [AMAG_W-1:0] a_mag;
    logic [BMAG_W-1:0] b_mag;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  function automatic logic signed [POS_W-1:0] sat_add(
    input logic signed [POS_W-1:0] a,
    input logic signed [DX_W-1:0]  d
  );
    logic signed [DX_W:0] s;
    logic [DX_W-POS_W+1:0] top;
    s   = {{(DX_W + 1 - POS_W){a[POS_W-1]}}, a} + {d[DX_W-1], d};
    top = s[DX_W:POS_W-1];
    if ((&top) || !(|top)) begin
      sat_add = s[POS_W-1:0];
    end else if (s[DX_W]) begin
      sat_add = {1'b1, {(POS_W - 1){1'b0}}};
    end else begin
      sat_add = {1'b0, {(POS_W - 1){1'b1}}};
    end
  endfunction

endpackage

### src/differential_drive_odometry_core.sv
// ----------------------------------------------------------------------------
// Differential drive odometry core
// Dead-reckoning pose of a two-wheel robot from cumulative wheel angles.
//
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// s        in         s_tvalid / s_tready    left and right wheel angle
// m        out        m_tvalid / m_tready    pos_x, pos_y, heading
//
// A request is taken only in idle. After the first, each runs the CORDIC at
// one step per cycle, then six products on the shared multiplier. The first
// request after reset only primes the previous angles and goes straight to
// the output. Reset restores the register defaults and clears the pose.
// The result sits in an output register; a stalled output delays only the
// return to idle, and a new request may be accepted while a result waits.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // left_wheel_angle [31:0], right_wheel_angle [63:32]
  input  logic [ddo_pkg::IN_W-1:0]          s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // pos_x [31:0], pos_y [63:32], heading [95:64]
  output logic [ddo_pkg::OUT_W-1:0]         m_tdata
);

  localparam int AW = ddo_pkg::ANGLE_W;

  ddo_pkg::seq_state_t state, state_next;

  logic [ddo_pkg::RAD_W-1:0]    radius;
  logic [ddo_pkg::INVSEP_W-1:0] inverse_separation;
  logic [AW-1:0]                prev_left, prev_right;
  logic                         primed;
  logic signed [ddo_pkg::POS_W-1:0] acc_x, acc_y;
  logic [AW-1:0]                acc_heading;

  logic signed [ddo_pkg::DELTA_W-1:0] d_left, d_right;
  logic signed [ddo_pkg::SUM_W-1:0]   wheel_sum, wheel_diff;
  logic signed [ddo_pkg::DIST_W-1:0]  travel;
  logic signed [ddo_pkg::T_W-1:0]     turn_t;
  logic signed [ddo_pkg::W_W-1:0]     omega_w;

  logic                               in_accept, out_load;
  logic [AW-1:0]                      in_left, in_right;
  logic                               cordic_start;
  ddo_pkg::unit_status_t              cor_status, mul_status;
  logic signed [ddo_pkg::TRIG_W-1:0]  cos_v, sin_v;
  ddo_pkg::mul_req_t                  mul_req;
  logic signed [ddo_pkg::PROD_W-1:0]  prod;
  logic                               mul_state;
  logic [ddo_pkg::OPA_W-1:0]          op_a, a_abs;
  logic [ddo_pkg::OPB_W-1:0]          op_b, b_abs;
  logic signed [ddo_pkg::DX_W-1:0]    dx;
  logic                               prod_neg, omega_fix, turn_fix;

  assign cfg_ready = 1'b1;
  assign in_left   = s_tdata[AW-1:0];
  assign in_right  = s_tdata[2*AW-1:AW];
  assign in_accept = s_tvalid && s_tready;
  assign out_load  = (state == ddo_pkg::S_OUT) && (!m_tvalid || m_tready);

  assign prod_neg  = prod[ddo_pkg::PROD_W-1];
  assign omega_fix = prod_neg && (|prod[ddo_pkg::OMEGA_SHIFT-1:0]);
  assign turn_fix  = prod_neg && (|prod[ddo_pkg::TURN_SHIFT-1:0]);
  assign dx        = prod[ddo_pkg::TRIG_SHIFT+ddo_pkg::DX_W-1:ddo_pkg::TRIG_SHIFT];

  ddo_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (acc_heading),
    .status(cor_status),
    .cosine(cos_v),
    .sine  (sin_v)
  );

  ddo_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_req),
    .status (mul_status),
    .product(prod)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ddo_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = primed ? ddo_pkg::S_CORDIC : ddo_pkg::S_OUT;
        end
      end
      ddo_pkg::S_CORDIC: if (cor_status.done) state_next = ddo_pkg::S_DIST;
      ddo_pkg::S_DIST:   if (mul_status.done) state_next = ddo_pkg::S_DX;
      ddo_pkg::S_DX:     if (mul_status.done) state_next = ddo_pkg::S_DY;
      ddo_pkg::S_DY:     if (mul_status.done) state_next = ddo_pkg::S_TURN;
      ddo_pkg::S_TURN:   if (mul_status.done) state_next = ddo_pkg::S_OMEGA;
      ddo_pkg::S_OMEGA:  if (mul_status.done) state_next = ddo_pkg::S_DELTA;
      ddo_pkg::S_DELTA:  if (mul_status.done) state_next = ddo_pkg::S_OUT;
      ddo_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ddo_pkg::S_IDLE;
        end
      end
      default: state_next = ddo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == ddo_pkg::S_IDLE);
    cordic_start = (state == ddo_pkg::S_CORDIC) && !cor_status.busy && !cor_status.done;
    mul_state    = 1'b1;
    op_a         = '0;
    op_b         = '0;
    unique case (state)
      ddo_pkg::S_DIST: begin
        op_a = {{(ddo_pkg::OPA_W - ddo_pkg::SUM_W){wheel_sum[ddo_pkg::SUM_W-1]}}, wheel_sum};
        op_b = {{(ddo_pkg::OPB_W - ddo_pkg::RAD_W){1'b0}}, radius};
      end
      ddo_pkg::S_DX: begin
        op_a = {{(ddo_pkg::OPA_W - ddo_pkg::DIST_W){travel[ddo_pkg::DIST_W-1]}}, travel};
        op_b = cos_v;
      end
      ddo_pkg::S_DY: begin
        op_a = {{(ddo_pkg::OPA_W - ddo_pkg::DIST_W){travel[ddo_pkg::DIST_W-1]}}, travel};
        op_b = sin_v;
      end
      ddo_pkg::S_TURN: begin
        op_a = {{(ddo_pkg::OPA_W - ddo_pkg::SUM_W){wheel_diff[ddo_pkg::SUM_W-1]}}, wheel_diff};
        op_b = {{(ddo_pkg::OPB_W - ddo_pkg::RAD_W){1'b0}}, radius};
      end
      ddo_pkg::S_OMEGA: begin
        op_a = {{(ddo_pkg::OPA_W - ddo_pkg::T_W){turn_t[ddo_pkg::T_W-1]}}, turn_t};
        op_b = {{(ddo_pkg::OPB_W - ddo_pkg::INVSEP_W){1'b0}}, inverse_separation};
      end
      ddo_pkg::S_DELTA: begin
        op_a = omega_w;
        op_b = {{(ddo_pkg::OPB_W - AW){1'b0}}, ddo_pkg::TURN_PER_RAD};
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
    a_abs         = op_a[ddo_pkg::OPA_W-1] ? (~op_a + 1'b1) : op_a;
    b_abs         = op_b[ddo_pkg::OPB_W-1] ? (~op_b + 1'b1) : op_b;
    mul_req.start = mul_state && !mul_status.busy && !mul_status.done;
    mul_req.neg   = op_a[ddo_pkg::OPA_W-1] ^ op_b[ddo_pkg::OPB_W-1];
    mul_req.a_mag = a_abs[ddo_pkg::AMAG_W-1:0];
    mul_req.b_mag = b_abs[ddo_pkg::BMAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ddo_pkg::S_IDLE;
      radius             <= ddo_pkg::RADIUS_RESET;
      inverse_separation <= ddo_pkg::INVSEP_RESET;
      prev_left          <= '0;
      prev_right         <= '0;
      primed             <= 1'b0;
      acc_x              <= '0;
      acc_y              <= '0;
      acc_heading        <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ddo_pkg::REG_WHEEL_RADIUS: radius <= cfg_data[ddo_pkg::RAD_W-1:0];
          ddo_pkg::REG_INV_SEP:      inverse_separation <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        prev_left  <= in_left;
        prev_right <= in_right;
        primed     <= 1'b1;
      end
      if (mul_status.done) begin
        if (state == ddo_pkg::S_DX) begin
          acc_x <= ddo_pkg::sat_add(acc_x, dx);
        end
        if (state == ddo_pkg::S_DY) begin
          acc_y <= ddo_pkg::sat_add(acc_y, dx);
        end
        if (state == ddo_pkg::S_DELTA) begin
          acc_heading <= acc_heading + prod[ddo_pkg::TURN_SHIFT+AW-1:ddo_pkg::TURN_SHIFT]
                       + {{(AW - 1){1'b0}}, turn_fix};
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      d_left  <= {in_left[AW-1], in_left} - {prev_left[AW-1], prev_left};
      d_right <= {in_right[AW-1], in_right} - {prev_right[AW-1], prev_right};
    end
    if (state == ddo_pkg::S_CORDIC) begin
      wheel_sum  <= {d_left[ddo_pkg::DELTA_W-1], d_left} + {d_right[ddo_pkg::DELTA_W-1], d_right};
      wheel_diff <= {d_right[ddo_pkg::DELTA_W-1], d_right} - {d_left[ddo_pkg::DELTA_W-1], d_left};
    end
    if (mul_status.done) begin
      if (state == ddo_pkg::S_DIST) begin
        travel <= prod[ddo_pkg::DIST_SHIFT+ddo_pkg::DIST_W-1:ddo_pkg::DIST_SHIFT];
      end
      if (state == ddo_pkg::S_TURN) begin
        turn_t <= prod[ddo_pkg::T_W-1:0];
      end
      if (state == ddo_pkg::S_OMEGA) begin
        omega_w <= prod[ddo_pkg::OMEGA_SHIFT+ddo_pkg::W_W-1:ddo_pkg::OMEGA_SHIFT]
                 + {{(ddo_pkg::W_W - 1){1'b0}}, omega_fix};
      end
    end
    if (out_load) begin
      m_tdata <= {acc_heading, acc_y, acc_x};
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_primes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> primed)
    else $error("primed flag not set after an accepted request");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cor_status.busy && mul_status.busy))
    else $error("CORDIC and multiplier busy at the same time");

  a_heading_hold: assert property (@(posedge clk) disable iff (rst)
    state != ddo_pkg::S_DELTA |=> $stable(acc_heading))
    else $error("heading changed outside the heading update");

  a_x_hold: assert property (@(posedge clk) disable iff (rst)
    state != ddo_pkg::S_DX |=> $stable(acc_x))
    else $error("x position changed outside the x update");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ddo_pkg::S_OUT)
    else $error("result raised outside the output state");
`endif

endmodule

### src/ddo_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC rotation unit
// Folds a binary angle into the right half plane and runs one shift-and-add
// rotation step per cycle to produce cosine and sine in signed Q4.30.
// ----------------------------------------------------------------------------
module ddo_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [ddo_pkg::ANGLE_W-1:0]            angle,
  output ddo_pkg::unit_status_t                  status,
  output logic signed [ddo_pkg::TRIG_W-1:0]      cosine,
  output logic signed [ddo_pkg::TRIG_W-1:0]      sine
);

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  ddo_pkg::cordic_state_t state, state_next;
  logic done;

  logic signed [ddo_pkg::TRIG_W-1:0] x, y, z;
  logic signed [ddo_pkg::TRIG_W-1:0] xs, ys, atan_step, z_init;
  logic                              flip, fold_flip;
  logic [STEP_W-1:0]                 step;
  logic [ddo_pkg::ATAN_IDX_W-1:0]    k;
  logic [ddo_pkg::ANGLE_W-1:0]       rotated, folded;

  assign rotated   = angle + ddo_pkg::QUARTER_TURN;
  assign fold_flip = rotated[ddo_pkg::ANGLE_W-1];
  assign folded    = fold_flip ? (angle ^ ddo_pkg::HALF_TURN) : angle;
  assign z_init    = {{(ddo_pkg::TRIG_W - ddo_pkg::ANGLE_W){folded[ddo_pkg::ANGLE_W-1]}},
                      folded};

  assign k         = ddo_pkg::ATAN_IDX_W'(step);
  assign xs        = x >>> k;
  assign ys        = y >>> k;
  assign atan_step = {{(ddo_pkg::TRIG_W - ddo_pkg::ANGLE_W){1'b0}}, ddo_pkg::ATAN_TURNS[k]};

  always_comb begin
    state_next = state;
    unique case (state)
      ddo_pkg::COR_IDLE: begin
        if (start) begin
          state_next = ddo_pkg::COR_RUN;
        end
      end
      ddo_pkg::COR_RUN: begin
        if (step == LAST_STEP) begin
          state_next = ddo_pkg::COR_FIN;
        end
      end
      ddo_pkg::COR_FIN: begin
        state_next = ddo_pkg::COR_IDLE;
      end
      default: begin
        state_next = ddo_pkg::COR_IDLE;
      end
    endcase
  end

  always_comb begin
    status.busy = (state != ddo_pkg::COR_IDLE);
    status.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::COR_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ddo_pkg::COR_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ddo_pkg::COR_IDLE: begin
        if (start) begin
          x    <= ddo_pkg::CORDIC_GAIN;
          y    <= '0;
          z    <= z_init;
          flip <= fold_flip;
          step <= '0;
        end
      end
      ddo_pkg::COR_RUN: begin
        if (!z[ddo_pkg::TRIG_W-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_step;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_step;
        end
        step <= step + 1'b1;
      end
      ddo_pkg::COR_FIN: begin
        cosine <= flip ? -x : x;
        sine   <= flip ? -y : y;
      end
      default: begin
      end
    endcase
  end

endmodule

### src/ddo_mul.sv
// ----------------------------------------------------------------------------
// Shared signed multiplier
// Forms the exact signed product of a 58-bit magnitude and a 32-bit magnitude
// from two 32x32 partial products over several cycles.
// ----------------------------------------------------------------------------
module ddo_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  ddo_pkg::mul_req_t                   req,
  output ddo_pkg::unit_status_t               status,
  output logic signed [ddo_pkg::PROD_W-1:0]   product
);

  localparam int AHI_W = ddo_pkg::AMAG_W - ddo_pkg::BMAG_W;

  ddo_pkg::mul_state_t state, state_next;
  logic done;

  logic [ddo_pkg::BMAG_W-1:0] a_lo;
  logic [AHI_W-1:0]           a_hi;
  logic [ddo_pkg::BMAG_W-1:0] b;
  logic                       neg;
  logic [ddo_pkg::PP_W-1:0]   pp;
  logic [ddo_pkg::BMAG_W-1:0] mul_a;
  logic [ddo_pkg::PP_W-1:0]   pp_next;
  logic [ddo_pkg::ACC_W-1:0]  acc;
  logic [ddo_pkg::PROD_W-1:0] acc_ext;

  assign acc_ext = {1'b0, acc};

  assign mul_a   = (state == ddo_pkg::MUL_HI)
                 ? {{(ddo_pkg::BMAG_W - AHI_W){1'b0}}, a_hi} : a_lo;
  assign pp_next = {{(ddo_pkg::PP_W - ddo_pkg::BMAG_W){1'b0}}, mul_a}
                 * {{(ddo_pkg::PP_W - ddo_pkg::BMAG_W){1'b0}}, b};

  always_comb begin
    state_next = state;
    unique case (state)
      ddo_pkg::MUL_IDLE: begin
        if (req.start) begin
          state_next = ddo_pkg::MUL_LO;
        end
      end
      ddo_pkg::MUL_LO:   state_next = ddo_pkg::MUL_HI;
      ddo_pkg::MUL_HI:   state_next = ddo_pkg::MUL_SUM;
      ddo_pkg::MUL_SUM:  state_next = ddo_pkg::MUL_SIGN;
      ddo_pkg::MUL_SIGN: state_next = ddo_pkg::MUL_IDLE;
      default:           state_next = ddo_pkg::MUL_IDLE;
    endcase
  end

  always_comb begin
    status.busy = (state != ddo_pkg::MUL_IDLE);
    status.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::MUL_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ddo_pkg::MUL_SIGN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ddo_pkg::MUL_IDLE: begin
        if (req.start) begin
          a_lo <= req.a_mag[ddo_pkg::BMAG_W-1:0];
          a_hi <= req.a_mag[ddo_pkg::AMAG_W-1:ddo_pkg::BMAG_W];
          b    <= req.b_mag;
          neg  <= req.neg;
        end
      end
      ddo_pkg::MUL_LO: begin
        pp <= pp_next;
      end
      ddo_pkg::MUL_HI: begin
        acc <= {{(ddo_pkg::ACC_W - ddo_pkg::PP_W){1'b0}}, pp};
        pp  <= pp_next;
      end
      ddo_pkg::MUL_SUM: begin
        acc <= acc + {pp[ddo_pkg::AMAG_W-1:0], {ddo_pkg::BMAG_W{1'b0}}};
      end
      ddo_pkg::MUL_SIGN: begin
        product <= neg ? (~acc_ext + 1'b1) : acc_ext;
      end
      default: begin
      end
    endcase
  end

endmodule
